// ----- hw/rtl/jmve_pkg.sv -----
// ----------------------------------------------------------------------------
// jmve_pkg: shared types and constants
// Phase codes, status codes, register indexes and the front/back record.
// ----------------------------------------------------------------------------
package jmve_pkg;

	localparam int MAX_KEY_CHARS = 32;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_KLEN = 3'd4;
	localparam logic [2:0] REG_KIND = 3'd5;
	localparam logic [2:0] REG_CAP  = 3'd6;
	localparam logic [2:0] REG_FALL = 3'd7;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_NOKEY = 3'd1;
	localparam logic [2:0] ST_TYPE  = 3'd2;
	localparam logic [2:0] ST_STR   = 3'd3;
	localparam logic [2:0] ST_OVF   = 3'd4;
	localparam logic [2:0] ST_TERM  = 3'd5;

	localparam logic [1:0] KIND_STR  = 2'd0;
	localparam logic [1:0] KIND_NUM  = 2'd1;
	localparam logic [1:0] KIND_BOOL = 2'd2;

	typedef enum logic [11:0] {
		PH_OUTSIDE   = 12'b0000_0000_0001,
		PH_TOKEN     = 12'b0000_0000_0010,
		PH_TOKEN_ESC = 12'b0000_0000_0100,
		PH_AFTER_KEY = 12'b0000_0000_1000,
		PH_VALUE_WS  = 12'b0000_0001_0000,
		PH_STR_BODY  = 12'b0000_0010_0000,
		PH_STR_ESC   = 12'b0000_0100_0000,
		PH_STR_FULL  = 12'b0000_1000_0000,
		PH_NUM       = 12'b0001_0000_0000,
		PH_NUM_TAIL  = 12'b0010_0000_0000,
		PH_BOOL      = 12'b0100_0000_0000,
		PH_DONE      = 12'b1000_0000_0000
	} phase_t;

	// one queued result: either a value byte or the final status
	typedef struct packed {
		logic        kind;
		logic [7:0]  vbyte;
		logic [31:0] num;
		logic [2:0]  status;
	} result_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0b ||
			c == 8'h0c || c == 8'h0d;
	endfunction

	function automatic logic [7:0] map_escape(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c == "n") r = 8'h0a;
		else if (c == "r") r = 8'h0d;
		else if (c == "t") r = 8'h09;
		else if (c == "b") r = 8'h08;
		else if (c == "f") r = 8'h0c;
		return r;
	endfunction

	function automatic logic [7:0] lit_true(input logic [2:0] p);
		logic [7:0] r;
		unique case (p)
			3'd0: r = "t";
			3'd1: r = "r";
			3'd2: r = "u";
			3'd3: r = "e";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] lit_false(input logic [2:0] p);
		logic [7:0] r;
		unique case (p)
			3'd0: r = "f";
			3'd1: r = "a";
			3'd2: r = "l";
			3'd3: r = "s";
			default: r = "e";
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/jmve_front.sv -----
// ----------------------------------------------------------------------------
// jmve_front: byte scanner
// Runs the per-byte parse state machine and pushes up to two results per byte.
// ----------------------------------------------------------------------------
module jmve_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [63:0]             cfg_data,
	input  logic                    in_fire,
	input  logic [7:0]              text_byte,
	input  logic                    end_of_line,
	output logic                    push0,
	output logic                    push1,
	output jmve_pkg::result_t       res0,
	output jmve_pkg::result_t       res1
);

	logic [255:0] key_q;
	logic [5:0]   klen_q;
	logic [1:0]   kind_q;
	logic [7:0]   cap_q;
	logic [31:0]  fall_q;

	jmve_pkg::phase_t phase_q, ph_n;
	logic [5:0]  tpos_q, tpos_n;
	logic        tmis_q, tmis_n;
	logic        tbs_q, tbs_n;
	logic [7:0]  emit_q, emit_n;
	logic [32:0] acc_q, acc_n;
	logic [2:0]  lpos_q, lpos_n;
	logic [1:0]  lcand_q, lcand_n;
	logic [2:0]  hst_q, hst_n;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			klen_q <= '0;
			kind_q <= jmve_pkg::KIND_STR;
			cap_q  <= 8'd64;
			fall_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				jmve_pkg::REG_KEY0: key_q[63:0]    <= cfg_data;
				jmve_pkg::REG_KEY1: key_q[127:64]  <= cfg_data;
				jmve_pkg::REG_KEY2: key_q[191:128] <= cfg_data;
				jmve_pkg::REG_KEY3: key_q[255:192] <= cfg_data;
				jmve_pkg::REG_KLEN: klen_q <= cfg_data[5:0];
				jmve_pkg::REG_KIND: kind_q <= cfg_data[1:0];
				jmve_pkg::REG_CAP:  cap_q  <= cfg_data[7:0];
				jmve_pkg::REG_FALL: fall_q <= cfg_data[31:0];
			endcase
		end
	end

	logic [5:0] eklen;
	assign eklen = (klen_q > 6'(jmve_pkg::MAX_KEY_CHARS)) ?
		6'(jmve_pkg::MAX_KEY_CHARS) : klen_q;

	logic [7:0] kbyte;
	assign kbyte = key_q[{tpos_q[4:0], 3'b000} +: 8];

	logic [35:0] acc_x10;
	assign acc_x10 = {1'b0, acc_q[31:0], 3'b000} + {3'b000, acc_q[31:0], 1'b0};

	// next state and results for one byte
	always_comb begin
		logic [7:0] c;
		logic       dig;
		logic       cmp_mis;
		logic       do_emit;
		logic [7:0] ebyte;
		logic       fin;
		logic [2:0] fst;
		logic [32:0] fval;
		logic [2:0] p;
		logic [1:0] lc;
		logic [35:0] nacc;
		logic       eot;
		c = text_byte;
		dig = c >= "0" && c <= "9";
		cmp_mis = (tpos_q >= eklen) || (c != kbyte);
		do_emit = 1'b0;
		ebyte = c;
		fin = 1'b0;
		fst = jmve_pkg::ST_OK;
		fval = '0;
		p = (lpos_q > 3'd4) ? 3'd4 : lpos_q;
		lc = lcand_q;
		nacc = '0;
		eot = 1'b0;
		ph_n = phase_q;
		tpos_n = tpos_q;
		tmis_n = tmis_q;
		tbs_n = tbs_q;
		emit_n = emit_q;
		acc_n = acc_q;
		lpos_n = lpos_q;
		lcand_n = lcand_q;
		hst_n = hst_q;

		if (phase_q != jmve_pkg::PH_DONE) begin
			if (c == 8'h00) begin
				eot = 1'b1;
			end else begin
				unique case (phase_q)
					jmve_pkg::PH_OUTSIDE, jmve_pkg::PH_AFTER_KEY: begin
						if (phase_q == jmve_pkg::PH_AFTER_KEY && jmve_pkg::is_space(c)) begin
						end else if (phase_q == jmve_pkg::PH_AFTER_KEY && c == ":") begin
							ph_n = jmve_pkg::PH_VALUE_WS;
						end else if (c == "\"") begin
							tpos_n = '0;
							tmis_n = 1'b0;
							tbs_n = 1'b0;
							ph_n = jmve_pkg::PH_TOKEN;
						end else begin
							ph_n = jmve_pkg::PH_OUTSIDE;
						end
					end
					jmve_pkg::PH_TOKEN: begin
						if (c == "\"") begin
							if (!tmis_q && !tbs_q && tpos_q == eklen)
								ph_n = jmve_pkg::PH_AFTER_KEY;
							else
								ph_n = jmve_pkg::PH_OUTSIDE;
						end else begin
							if (c == "\\") begin
								tbs_n = 1'b1;
								ph_n = jmve_pkg::PH_TOKEN_ESC;
							end
							if (cmp_mis) tmis_n = 1'b1;
							if (tpos_q < 6'd63) tpos_n = tpos_q + 6'd1;
						end
					end
					jmve_pkg::PH_TOKEN_ESC: begin
						if (cmp_mis) tmis_n = 1'b1;
						if (tpos_q < 6'd63) tpos_n = tpos_q + 6'd1;
						ph_n = jmve_pkg::PH_TOKEN;
					end
					jmve_pkg::PH_VALUE_WS, jmve_pkg::PH_BOOL: begin
						if (phase_q == jmve_pkg::PH_VALUE_WS && jmve_pkg::is_space(c)) begin
						end else if (phase_q == jmve_pkg::PH_VALUE_WS &&
							kind_q == jmve_pkg::KIND_STR) begin
							if (c == "\"") begin
								emit_n = '0;
								ph_n = (cap_q <= 8'd1) ? jmve_pkg::PH_STR_FULL :
									jmve_pkg::PH_STR_BODY;
							end else begin
								fin = 1'b1;
								fst = jmve_pkg::ST_TYPE;
							end
						end else if (phase_q == jmve_pkg::PH_VALUE_WS &&
							kind_q == jmve_pkg::KIND_NUM) begin
							if (dig) begin
								acc_n = 33'(c - "0");
								ph_n = jmve_pkg::PH_NUM;
							end else begin
								fin = 1'b1;
								fst = jmve_pkg::ST_TYPE;
							end
						end else if (phase_q == jmve_pkg::PH_VALUE_WS &&
							kind_q != jmve_pkg::KIND_BOOL) begin
							fin = 1'b1;
							fst = jmve_pkg::ST_TYPE;
						end else begin
							// boolean literal step
							if (phase_q == jmve_pkg::PH_VALUE_WS) begin
								lc = 2'b11;
								p = 3'd0;
							end
							if (lc[0] && c != jmve_pkg::lit_true(p)) lc[0] = 1'b0;
							if (lc[1] && c != jmve_pkg::lit_false(p)) lc[1] = 1'b0;
							ph_n = jmve_pkg::PH_BOOL;
							lcand_n = lc;
							if (lc == 2'b00) begin
								fin = 1'b1;
								fst = jmve_pkg::ST_TYPE;
							end else if (lc[0] && p == 3'd3) begin
								fin = 1'b1;
								fval = 33'd1;
							end else if (lc[1] && p == 3'd4) begin
								fin = 1'b1;
							end else begin
								lpos_n = p + 3'd1;
							end
						end
					end
					jmve_pkg::PH_STR_BODY: begin
						if (c == "\"") fin = 1'b1;
						else if (c == "\\") ph_n = jmve_pkg::PH_STR_ESC;
						else do_emit = 1'b1;
					end
					jmve_pkg::PH_STR_ESC: begin
						do_emit = 1'b1;
						ebyte = jmve_pkg::map_escape(c);
					end
					jmve_pkg::PH_STR_FULL: begin
						fin = 1'b1;
						fst = (c == "\"") ? jmve_pkg::ST_OK : jmve_pkg::ST_STR;
					end
					jmve_pkg::PH_NUM: begin
						if (dig) begin
							if (!acc_q[32]) begin
								nacc = acc_x10 + 36'(c - "0");
								acc_n = (nacc[35:32] != 4'd0) ? 33'h1_0000_0000 :
									nacc[32:0];
							end
						end else if (acc_q[32]) begin
							fin = 1'b1;
							fst = jmve_pkg::ST_OVF;
						end else if (jmve_pkg::is_space(c)) begin
							ph_n = jmve_pkg::PH_NUM_TAIL;
						end else if (c == "," || c == "}") begin
							fin = 1'b1;
							fval = acc_q;
						end else begin
							fin = 1'b1;
							fst = jmve_pkg::ST_TERM;
						end
					end
					jmve_pkg::PH_NUM_TAIL: begin
						if (jmve_pkg::is_space(c)) begin
						end else if (c == "," || c == "}") begin
							fin = 1'b1;
							fval = acc_q;
						end else begin
							fin = 1'b1;
							fst = jmve_pkg::ST_TERM;
						end
					end
					default: begin
					end
				endcase
			end
		end

		// end of text, either from a zero byte or from the end of the line
		if (!fin && (eot || end_of_line) && ph_n != jmve_pkg::PH_DONE) begin
			fin = 1'b1;
			unique case (ph_n)
				jmve_pkg::PH_VALUE_WS, jmve_pkg::PH_BOOL: fst = jmve_pkg::ST_TYPE;
				jmve_pkg::PH_STR_ESC: begin
					fst = jmve_pkg::ST_STR;
					// a byte that ends the escape has already been emitted
					if (!do_emit) begin
						do_emit = 1'b1;
						ebyte = "\\";
					end
				end
				jmve_pkg::PH_STR_BODY, jmve_pkg::PH_STR_FULL: fst = jmve_pkg::ST_STR;
				jmve_pkg::PH_NUM, jmve_pkg::PH_NUM_TAIL: begin
					if (acc_n[32]) fst = jmve_pkg::ST_OVF;
					else fval = acc_n;
				end
				default: fst = jmve_pkg::ST_NOKEY;
			endcase
		end

		if (do_emit) begin
			if (emit_q < 8'd255) emit_n = emit_q + 8'd1;
			if (!fin)
				ph_n = ({1'b0, emit_n} + 9'd1 >= {1'b0, cap_q}) ?
					jmve_pkg::PH_STR_FULL : jmve_pkg::PH_STR_BODY;
		end
		if (fin) begin
			ph_n = jmve_pkg::PH_DONE;
			hst_n = fst;
			acc_n = fval;
		end

		// results: optional value byte, then final status on end of line
		res0 = '0;
		res1 = '0;
		res0.kind = 1'b0;
		res0.vbyte = ebyte;
		res1.kind = 1'b1;
		res1.status = hst_n;
		res1.num = (hst_n == jmve_pkg::ST_OK) ? acc_n[31:0] : fall_q;
		push0 = in_fire && do_emit;
		push1 = in_fire && end_of_line;
		if (!do_emit) begin
			res0 = res1;
			push0 = push1;
			push1 = 1'b0;
		end
	end

	// advance the scanner; the line state returns to reset at end of line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jmve_pkg::PH_OUTSIDE;
			tpos_q  <= '0;
			tmis_q  <= 1'b0;
			tbs_q   <= 1'b0;
			emit_q  <= '0;
			acc_q   <= '0;
			lpos_q  <= '0;
			lcand_q <= 2'b11;
			hst_q   <= jmve_pkg::ST_OK;
		end else if (in_fire) begin
			if (end_of_line) begin
				phase_q <= jmve_pkg::PH_OUTSIDE;
				tpos_q  <= '0;
				tmis_q  <= 1'b0;
				tbs_q   <= 1'b0;
				emit_q  <= '0;
				acc_q   <= '0;
				lpos_q  <= '0;
				lcand_q <= 2'b11;
				hst_q   <= jmve_pkg::ST_OK;
			end else begin
				phase_q <= ph_n;
				tpos_q  <= tpos_n;
				tmis_q  <= tmis_n;
				tbs_q   <= tbs_n;
				emit_q  <= emit_n;
				acc_q   <= acc_n;
				lpos_q  <= lpos_n;
				lcand_q <= lcand_n;
				hst_q   <= hst_n;
			end
		end
	end

endmodule

// ----- hw/rtl/jmve_queue.sv -----
// ----------------------------------------------------------------------------
// jmve_queue: result queue
// Small queue that takes up to two results a cycle and hands one out.
// ----------------------------------------------------------------------------
module jmve_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push0,
	input  logic                    push1,
	input  jmve_pkg::result_t       res0,
	input  jmve_pkg::result_t       res1,
	output logic                    room,
	output logic                    nonempty,
	output jmve_pkg::result_t       head,
	input  logic                    pop
);

	jmve_pkg::result_t mem_q [jmve_pkg::QDEPTH];
	logic [jmve_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [jmve_pkg::QPTR_W:0]   cnt_q;

	logic [jmve_pkg::QPTR_W-1:0] wr1;
	assign wr1 = wr_q + 1'b1;

	// room for two more, counting the entry that leaves this cycle not at all
	assign room = cnt_q <= (jmve_pkg::QPTR_W + 1)'(jmve_pkg::QDEPTH - 2);
	assign nonempty = cnt_q != '0;
	assign head = mem_q[rd_q];

	// store pushed results
	always_ff @(posedge clk) begin
		if (push0) mem_q[wr_q] <= res0;
		if (push1) mem_q[wr1] <= res1;
	end

	// move pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + jmve_pkg::QPTR_W'(push0) + jmve_pkg::QPTR_W'(push1);
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (jmve_pkg::QPTR_W + 1)'(push0) + (jmve_pkg::QPTR_W + 1)'(push1)
				- (jmve_pkg::QPTR_W + 1)'(pop);
		end
	end

endmodule

// ----- hw/rtl/jmve_back.sv -----
// ----------------------------------------------------------------------------
// jmve_back: output stage
// Drains the queue into a registered master-side stream.
// ----------------------------------------------------------------------------
module jmve_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    nonempty,
	input  jmve_pkg::result_t       head,
	output logic                    pop,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [47:0]             m_tdata,
	output logic                    m_tlast,
	output logic                    m_tuser
);

	logic            valid_q;
	jmve_pkg::result_t r_q;

	assign pop = nonempty && (!valid_q || m_tready);

	// load the output register whenever it is empty or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (!valid_q || m_tready) valid_q <= nonempty;
	end

	always_ff @(posedge clk) begin
		if (pop) r_q <= head;
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = r_q.kind;
	assign m_tlast  = r_q.kind;
	assign m_tdata  = {5'd0, r_q.status, r_q.num, r_q.vbyte};

endmodule

// ----- hw/rtl/json_member_value_extractor_top.sv -----
// ----------------------------------------------------------------------------
// json_member_value_extractor_top: JSON member value extractor
// Scans JSON text bytes and reports the value of one configured member.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream carries one text byte per transfer, tlast marks the line end.
//   m_* stream returns string value bytes (tuser 0) and one final status per
//   line (tuser 1, tlast 1). A byte gives at most two results.
//   Configure through cfg_we/cfg_index/cfg_data while the block is idle.
// Timing:
//   One byte per cycle is accepted while s_tready is high. Each result is
//   registered in the result queue and then in the output register. The
//   four-entry queue holds results while the receiver stalls; s_tready
//   drops when fewer than two entries are free, so no result is lost.
// Reset:
//   arst_n clears the scanner to the start of a line, empties the queue and
//   loads the register defaults (capacity 64, everything else zero).
// ----------------------------------------------------------------------------
module json_member_value_extractor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // text_byte
	input  logic        s_tlast,   // end_of_line
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // value_byte[7:0], number_value[39:8], status[42:40]
	output logic        m_tlast,   // last_of_line
	output logic        m_tuser    // result_kind
);

	logic push0, push1, room, nonempty, pop, in_fire;
	jmve_pkg::result_t res0, res1, head;

	assign s_tready = room;
	assign in_fire = s_tvalid && room;

	jmve_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_fire, .text_byte(s_tdata), .end_of_line(s_tlast),
		.push0, .push1, .res0, .res1
	);

	jmve_queue u_queue (
		.clk, .arst_n, .push0, .push1, .res0, .res1,
		.room, .nonempty, .head, .pop
	);

	jmve_back u_back (
		.clk, .arst_n, .nonempty, .head, .pop,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
	);

endmodule

// ----- dv/json_member_value_extractor_top_chk.sv -----
// ----------------------------------------------------------------------------
// json_member_value_extractor_top_chk: result checker
// Watches the text and result streams and the register port, keeps its own
// model of the member scanner and compares each result transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module json_member_value_extractor_top_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        m_tlast,
	input  logic        m_tuser,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic        kind;
		logic [7:0]  vbyte;
		logic [31:0] num;
		logic [2:0]  status;
		logic        last;
	} line_result_t;

	line_result_t expected_results[$];

	logic [63:0] key_reg [4];
	logic [5:0]  key_len;
	logic [1:0]  kind_reg;
	logic [7:0]  cap_reg;
	logic [31:0] fall_reg;

	jmve_pkg::phase_t phase;
	logic [5:0]  tok_pos;
	logic        tok_miss;
	logic        tok_bs;
	logic [7:0]  emit_cnt;
	logic [32:0] acc;
	logic [2:0]  lit_pos;
	logic [1:0]  lit_cand;
	logic [2:0]  held_st;

	assign pending = expected_results.size();

	function automatic logic blank(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic [7:0] unescape(input logic [7:0] c);
		case (c)
			"n": return 8'h0a;
			"r": return 8'h0d;
			"t": return 8'h09;
			"b": return 8'h08;
			"f": return 8'h0c;
			default: return c;
		endcase
	endfunction

	function automatic logic [5:0] klen_eff();
		return key_len > jmve_pkg::MAX_KEY_CHARS ? 6'(jmve_pkg::MAX_KEY_CHARS) : key_len;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		line_result_t r;
		r = '0;
		r.vbyte = b;
		expected_results.push_back(r);
	endtask

	task automatic conclude(input logic [2:0] st, input logic [32:0] v);
		phase = jmve_pkg::PH_DONE;
		held_st = st;
		acc = v;
	endtask

	task automatic clear_line();
		phase = jmve_pkg::PH_OUTSIDE;
		tok_pos = 0;
		tok_miss = 0;
		tok_bs = 0;
		emit_cnt = 0;
		acc = 0;
		lit_pos = 0;
		lit_cand = 2'b11;
		held_st = jmve_pkg::ST_OK;
	endtask

	task automatic key_compare(input logic [7:0] c);
		logic [7:0] k;
		k = key_reg[tok_pos[4:3]][8*tok_pos[2:0] +: 8];
		if (tok_pos >= klen_eff() || c != k) tok_miss = 1;
		if (tok_pos < 63) tok_pos++;
	endtask

	task automatic plain_char(input logic [7:0] c);
		phase = jmve_pkg::PH_OUTSIDE;
		if (c == "\"") begin
			tok_pos = 0;
			tok_miss = 0;
			tok_bs = 0;
			phase = jmve_pkg::PH_TOKEN;
		end
	endtask

	task automatic count_emit();
		if (emit_cnt < 255) emit_cnt++;
		phase = (int'(emit_cnt) + 1 >= int'(cap_reg)) ? jmve_pkg::PH_STR_FULL
			: jmve_pkg::PH_STR_BODY;
	endtask

	task automatic literal_char(input logic [7:0] c);
		logic [2:0] p;
		p = (lit_pos > 3'd4) ? 3'd4 : lit_pos;
		if (lit_cand[0] && c != jmve_pkg::lit_true(p)) lit_cand[0] = 0;
		if (lit_cand[1] && c != jmve_pkg::lit_false(p)) lit_cand[1] = 0;
		if (lit_cand == 0) conclude(jmve_pkg::ST_TYPE, 0);
		else if (lit_cand[0] && p == 3) conclude(jmve_pkg::ST_OK, 1);
		else if (lit_cand[1] && p == 4) conclude(jmve_pkg::ST_OK, 0);
		else lit_pos = p + 3'd1;
	endtask

	task automatic text_ends();
		case (phase)
			jmve_pkg::PH_OUTSIDE, jmve_pkg::PH_TOKEN, jmve_pkg::PH_TOKEN_ESC,
			jmve_pkg::PH_AFTER_KEY: conclude(jmve_pkg::ST_NOKEY, 0);
			jmve_pkg::PH_VALUE_WS, jmve_pkg::PH_BOOL: conclude(jmve_pkg::ST_TYPE, 0);
			jmve_pkg::PH_STR_ESC: begin
				push_byte("\\");
				conclude(jmve_pkg::ST_STR, 0);
			end
			jmve_pkg::PH_STR_BODY, jmve_pkg::PH_STR_FULL: conclude(jmve_pkg::ST_STR, 0);
			jmve_pkg::PH_NUM, jmve_pkg::PH_NUM_TAIL: begin
				if (acc[32]) conclude(jmve_pkg::ST_OVF, 0);
				else conclude(jmve_pkg::ST_OK, acc);
			end
			default: ;
		endcase
	endtask

	task automatic scan_char(input logic [7:0] c);
		case (phase)
			jmve_pkg::PH_OUTSIDE: plain_char(c);
			jmve_pkg::PH_TOKEN: begin
				if (c == "\"") begin
					if (!tok_miss && !tok_bs && tok_pos == klen_eff())
						phase = jmve_pkg::PH_AFTER_KEY;
					else phase = jmve_pkg::PH_OUTSIDE;
				end else begin
					if (c == "\\") begin
						tok_bs = 1;
						phase = jmve_pkg::PH_TOKEN_ESC;
					end
					key_compare(c);
				end
			end
			jmve_pkg::PH_TOKEN_ESC: begin
				key_compare(c);
				phase = jmve_pkg::PH_TOKEN;
			end
			jmve_pkg::PH_AFTER_KEY: begin
				if (!blank(c)) begin
					if (c == ":") phase = jmve_pkg::PH_VALUE_WS;
					else plain_char(c);
				end
			end
			jmve_pkg::PH_VALUE_WS: begin
				if (!blank(c)) begin
					case (kind_reg)
						jmve_pkg::KIND_STR: begin
							if (c == "\"") begin
								emit_cnt = 0;
								phase = (cap_reg <= 1) ? jmve_pkg::PH_STR_FULL
									: jmve_pkg::PH_STR_BODY;
							end else conclude(jmve_pkg::ST_TYPE, 0);
						end
						jmve_pkg::KIND_NUM: begin
							if (c >= "0" && c <= "9") begin
								acc = 33'(c - "0");
								phase = jmve_pkg::PH_NUM;
							end else conclude(jmve_pkg::ST_TYPE, 0);
						end
						jmve_pkg::KIND_BOOL: begin
							lit_cand = 2'b11;
							lit_pos = 0;
							phase = jmve_pkg::PH_BOOL;
							literal_char(c);
						end
						default: conclude(jmve_pkg::ST_TYPE, 0);
					endcase
				end
			end
			jmve_pkg::PH_STR_BODY: begin
				if (c == "\"") conclude(jmve_pkg::ST_OK, 0);
				else if (c == "\\") phase = jmve_pkg::PH_STR_ESC;
				else begin
					push_byte(c);
					count_emit();
				end
			end
			jmve_pkg::PH_STR_ESC: begin
				push_byte(unescape(c));
				count_emit();
			end
			jmve_pkg::PH_STR_FULL:
				conclude(c == "\"" ? jmve_pkg::ST_OK : jmve_pkg::ST_STR, 0);
			jmve_pkg::PH_NUM: begin
				if (c >= "0" && c <= "9") begin
					if (!acc[32]) begin
						logic [36:0] t;
						t = 37'(acc) * 10 + 37'(c - "0");
						acc = (t > 37'hffff_ffff) ? 33'h1_0000_0000 : t[32:0];
					end
				end else if (acc[32]) conclude(jmve_pkg::ST_OVF, 0);
				else if (blank(c)) phase = jmve_pkg::PH_NUM_TAIL;
				else if (c == "," || c == "}") conclude(jmve_pkg::ST_OK, acc);
				else conclude(jmve_pkg::ST_TERM, 0);
			end
			jmve_pkg::PH_NUM_TAIL: begin
				if (!blank(c)) begin
					if (c == "," || c == "}") conclude(jmve_pkg::ST_OK, acc);
					else conclude(jmve_pkg::ST_TERM, 0);
				end
			end
			jmve_pkg::PH_BOOL: literal_char(c);
			default: ;
		endcase
	endtask

	task automatic take_byte(input logic [7:0] c, input logic eol);
		line_result_t r;
		if (phase != jmve_pkg::PH_DONE) begin
			if (c == 0) text_ends();
			else scan_char(c);
		end
		if (eol) begin
			if (phase != jmve_pkg::PH_DONE) text_ends();
			r = '0;
			r.kind = 1;
			r.num = (held_st == jmve_pkg::ST_OK) ? acc[31:0] : fall_reg;
			r.status = held_st;
			r.last = 1;
			expected_results.push_back(r);
			clear_line();
		end
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// track registers, text transfers and result transfers
	always @(posedge clk or negedge arst_n) begin
		line_result_t e;
		if (!arst_n) begin
			key_reg = '{default: '0};
			key_len = 0;
			kind_reg = 0;
			cap_reg = 64;
			fall_reg = 0;
			clear_line();
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0)
					report("unexpected result", 64'(m_tdata), 64'd0);
				else begin
					e = expected_results.pop_front();
					if (m_tuser !== e.kind)
						report("result_kind", 64'(m_tuser), 64'(e.kind));
					if (m_tdata[7:0] !== e.vbyte)
						report("value_byte", 64'(m_tdata[7:0]), 64'(e.vbyte));
					if (m_tdata[39:8] !== e.num)
						report("number_value", 64'(m_tdata[39:8]), 64'(e.num));
					if (m_tdata[42:40] !== e.status)
						report("status", 64'(m_tdata[42:40]), 64'(e.status));
					if (m_tlast !== e.last)
						report("last_of_line", 64'(m_tlast), 64'(e.last));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					jmve_pkg::REG_KEY0, jmve_pkg::REG_KEY1, jmve_pkg::REG_KEY2,
					jmve_pkg::REG_KEY3: key_reg[cfg_index[1:0]] = cfg_data;
					jmve_pkg::REG_KLEN: key_len = cfg_data[5:0];
					jmve_pkg::REG_KIND: kind_reg = cfg_data[1:0];
					jmve_pkg::REG_CAP: cap_reg = cfg_data[7:0];
					jmve_pkg::REG_FALL: fall_reg = cfg_data[31:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
		end
	end

endmodule

// ----- dv/json_member_value_extractor_top_tb.sv -----
// ----------------------------------------------------------------------------
// json_member_value_extractor_top_tb: member extractor testbench
// Feeds JSON lines built around a configured key under random stalls on both
// streams, across key, value kind, capacity and fallback settings; the
// checker compares every result with its prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module json_member_value_extractor_top_tb;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	int          fail_count;
	int          pending;
	int          idle_cycles;
	int          bytes_sent;
	logic [7:0]  key_text [32];
	int          key_n;
	logic [7:0]  line_buf [$];

	json_member_value_extractor_top DUT (.*);
	json_member_value_extractor_top_chk u_chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// receiver stalls at random between results
	initial begin
		int gap;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			if (gap != 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// count cycles with no transfer on either stream
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 3000) begin
			$display("json_member_value_extractor_top_tb: done, errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_key(input int n, input logic [7:0] fill_hi);
		logic [63:0] w [4];
		for (int i = 0; i < 32; i++) begin
			key_text[i] = (i < n) ? 8'($urandom_range("a", "z")) : fill_hi;
			w[i / 8][8 * (i % 8) +: 8] = key_text[i];
		end
		key_n = n;
		for (int i = 0; i < 4; i++) write_reg(3'(i), w[i]);
		write_reg(jmve_pkg::REG_KLEN, 64'(n));
	endtask

	task automatic send_line(input int spread);
		int gap;
		for (int i = 0; i < line_buf.size(); i++) begin
			gap = (spread == 0) ? 0 : $urandom_range(0, 16);
			if (gap != 0) begin
				s_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1;
			s_tdata <= line_buf[i];
			s_tlast <= (i == line_buf.size() - 1);
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			bytes_sent++;
		end
		s_tvalid <= 0;
		line_buf.delete();
		@(posedge clk);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endtask

	task automatic put_key(input int damage);
		line_buf.push_back("\"");
		for (int i = 0; i < key_n; i++) begin
			if (damage == 1 && i == key_n - 1) line_buf.push_back("\\");
			line_buf.push_back((damage == 2 && i == 0) ? 8'h7e : key_text[i]);
		end
		if (damage == 3) line_buf.push_back("x");
		line_buf.push_back("\"");
	endtask

	task automatic put_space();
		repeat ($urandom_range(0, 2))
			line_buf.push_back(8'(($urandom_range(0, 1)) ? 8'h20 : $urandom_range(9, 13)));
	endtask

	// one random line: decoys, then the key and a value, sometimes broken
	task automatic build_line(input logic [1:0] kind);
		int r;
		put_str("{");
		if ($urandom_range(0, 2) == 0) begin
			put_key($urandom_range(1, 3));
			put_str(":1,");
		end
		if ($urandom_range(0, 4) == 0) begin
			put_key(0);
			put_str(" x \"q\\\"\":2,");
		end
		if ($urandom_range(0, 9) != 0) begin
			put_key(0);
			put_space();
			put_str(":");
			put_space();
			r = $urandom_range(0, 9);
			case (kind)
				jmve_pkg::KIND_STR: begin
					if (r != 0) line_buf.push_back("\"");
					repeat ($urandom_range(0, 6)) begin
						if ($urandom_range(0, 4) == 0) begin
							line_buf.push_back("\\");
							line_buf.push_back(8'($urandom_range(1, 255)));
						end else line_buf.push_back(8'($urandom_range(1, 255)));
					end
					if (r > 2) line_buf.push_back("\"");
				end
				jmve_pkg::KIND_NUM: begin
					if (r == 0) line_buf.push_back("-");
					repeat ($urandom_range(1, (r == 1) ? 14 : 10))
						line_buf.push_back(8'($urandom_range("0", "9")));
					if (r == 2) line_buf.push_back(";");
					put_space();
				end
				default: begin
					if (r == 0) line_buf.push_back(8'($urandom_range(1, 255)));
					else if (r < 5) put_str("true");
					else if (r < 9) put_str("false");
					else put_str("fals");
				end
			endcase
		end
		if ($urandom_range(0, 1)) put_str(",\"z\":0}");
		else if ($urandom_range(0, 3) == 0) line_buf.push_back(8'h00);
		if ($urandom_range(0, 7) == 0) line_buf.push_back(8'($urandom_range(0, 255)));
		if (line_buf.size() == 0) line_buf.push_back("}");
	endtask

	task automatic configure(input logic [1:0] kind, input logic [7:0] cap, input int n);
		set_key(n, 8'($urandom_range(0, 255)));
		write_reg(jmve_pkg::REG_KIND, 64'(kind));
		write_reg(jmve_pkg::REG_CAP, 64'(cap));
		write_reg(jmve_pkg::REG_FALL, {$urandom, $urandom});
	endtask

	initial begin
		logic [1:0] kind;
		logic [7:0] cap;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = jmve_pkg::REG_KEY0;
		cfg_data = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tlast = 0;
		bytes_sent = 0;
		key_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: defaults, empty key, full key, each kind and edge
		put_str("{\"\":\"ab\"}");
		send_line(0);
		drain();
		configure(jmve_pkg::KIND_NUM, 8'd64, 32);
		put_key(0);
		put_str(":4294967295}");
		send_line(0);
		put_key(0);
		put_str(":4294967296,");
		send_line(0);
		drain();
		configure(jmve_pkg::KIND_STR, 8'd1, 1);
		put_key(0);
		put_str(":\"\"");
		send_line(0);
		drain();
		configure(jmve_pkg::KIND_STR, 8'd255, 3);
		put_key(0);
		put_str(":\"\\n\\");
		line_buf.push_back(8'hff);
		line_buf.push_back(8'h00);
		send_line(1);
		drain();
		configure(jmve_pkg::KIND_BOOL, 8'd8, 2);
		put_key(0);
		put_str(":true");
		send_line(0);
		drain();
		configure(2'd3, 8'd0, 2);
		put_key(0);
		put_str(":1");
		send_line(0);
		drain();
		write_reg(jmve_pkg::REG_KLEN, 64'd63);
		write_reg(jmve_pkg::REG_KIND, 64'(jmve_pkg::KIND_NUM));
		put_key(0);
		put_str(":7}");
		send_line(0);
		drain();

		// random phases over settings, with a full pause now and then
		while (bytes_sent < 1450) begin
			kind = 2'($urandom_range(0, 2));
			cap = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(1, 6));
			configure(kind, cap, $urandom_range(0, 3) == 0 ? $urandom_range(0, 32)
				: $urandom_range(1, 4));
			repeat ($urandom_range(4, 12)) begin
				if (bytes_sent < 1450) begin
					build_line(kind);
					send_line($urandom_range(0, 2));
					if ($urandom_range(0, 9) == 0) while (pending != 0) @(posedge clk);
				end
			end
			drain();
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0) $display("json_member_value_extractor_top_tb: done, clean");
		else $display("json_member_value_extractor_top_tb: done, errors");
		$finish;
	end

endmodule
